FILE: src/lpmr_pkg.sv
// ----------------------------------------------------------------------------
// lpmr_pkg
// Shared types and constants of the length-prefixed message ring.
// ----------------------------------------------------------------------------
package lpmr_pkg;

	localparam int unsigned STORE_BYTES_DEF = 1024;
	localparam int unsigned CMD_QUEUE_DEPTH = 2;
	localparam int unsigned PADDR_W = 3;

	localparam logic [7:0] LEN_LIMIT = 8'hFF;
	localparam logic [7:0] MRL_RESET = 8'hFF;
	localparam logic [9:0] DROP_SAT = 10'd1023;

	localparam logic REG_MAX_READ_LENGTH = 1'b0;

	typedef enum logic [1:0] {
		OP_BEGIN = 2'd0,
		OP_PUSH  = 2'd1,
		OP_POP   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_POPPED       = 3'd0,
		ST_EMPTY        = 3'd1,
		ST_WRAP         = 3'd2,
		ST_TOO_LARGE    = 3'd3,
		ST_BEGIN_OK     = 3'd4,
		ST_BEGIN_REJECT = 3'd5,
		ST_PUSH_OK      = 3'd6,
		ST_PUSH_REJECT  = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		CMD_BEGIN,
		CMD_BEGIN_BAD,
		CMD_PUSH,
		CMD_POP,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data_byte;
		logic [7:0] msg_length;
	} cmd_t;

	typedef enum logic [2:0] {
		ENG_IDLE,
		ENG_FIT,
		ENG_DROP_CHECK,
		ENG_DROP_WAIT,
		ENG_POP_HEAD,
		ENG_POP_BYTE,
		ENG_EMIT
	} eng_state_t;

endpackage

FILE: src/lpmr_cmd_if.sv
// ----------------------------------------------------------------------------
// lpmr_cmd_if
// Request channel of the message ring: operation, data byte and length.
// ----------------------------------------------------------------------------
interface lpmr_cmd_if;

	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] data_byte;
	logic [7:0] msg_length;

	modport source (output valid, operation, data_byte, msg_length, input ready);
	modport sink (input valid, operation, data_byte, msg_length, output ready);

endinterface

FILE: src/lpmr_rsp_if.sv
// ----------------------------------------------------------------------------
// lpmr_rsp_if
// Result channel of the message ring: popped byte, last flag, status, drops.
// ----------------------------------------------------------------------------
interface lpmr_rsp_if;

	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic [2:0] status;
	logic [9:0] dropped_count;

	modport source (output valid, out_byte, last, status, dropped_count, input ready);
	modport sink (input valid, out_byte, last, status, dropped_count, output ready);

endinterface

FILE: src/lpmr_front.sv
// ----------------------------------------------------------------------------
// lpmr_front
// Accepts requests, decodes them into commands and queues them for the engine.
// ----------------------------------------------------------------------------
module lpmr_front (
	input  logic              clk,
	input  logic              arst_n,
	lpmr_cmd_if.sink          cmd,
	output lpmr_pkg::cmd_t    q_head,
	output logic              q_valid,
	input  logic              q_pop
);
	import lpmr_pkg::*;

	cmd_t       fifo_q [CMD_QUEUE_DEPTH];
	cmd_t       decoded;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	always_comb begin
		decoded.data_byte  = cmd.data_byte;
		decoded.msg_length = cmd.msg_length;
		unique case (op_t'(cmd.operation))
			OP_BEGIN: begin
				decoded.kind = (cmd.msg_length == LEN_LIMIT) ? CMD_BEGIN_BAD : CMD_BEGIN;
			end
			OP_PUSH: begin
				decoded.kind = CMD_PUSH;
			end
			OP_POP: begin
				decoded.kind = CMD_POP;
			end
			OP_NONE: begin
				decoded.kind = CMD_NOP;
			end
		endcase
	end

	assign cmd.ready = (cnt_q != 2'(CMD_QUEUE_DEPTH));
	assign q_valid   = (cnt_q != 2'd0);
	assign q_head    = fifo_q[rd_ptr_q];
	assign push      = cmd.valid && cmd.ready;
	assign pop       = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: src/lpmr_back.sv
// ----------------------------------------------------------------------------
// lpmr_back
// Command engine: owns the record store and the ring indexes, carries out
// begin, push and pop commands and holds the result register.
// ----------------------------------------------------------------------------
module lpmr_back #(
	parameter int unsigned STORE_BYTES = lpmr_pkg::STORE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        max_read_length,
	input  lpmr_pkg::cmd_t    q_head,
	input  logic              q_valid,
	output logic              q_pop,
	lpmr_rsp_if.source        rsp
);
	import lpmr_pkg::*;

	localparam int unsigned AW = $clog2(STORE_BYTES);

	typedef logic [AW-1:0] idx_t;
	typedef logic [AW:0]   wide_t;

	localparam wide_t SIZE_W = wide_t'(STORE_BYTES);
	localparam wide_t LAST_W = wide_t'(STORE_BYTES - 1);

	logic [7:0] mem [STORE_BYTES];
	logic [7:0] rdata_q;
	logic       mem_we;
	idx_t       mem_wa;
	logic [7:0] mem_wd;
	logic       mem_re;
	idx_t       mem_ra;

	eng_state_t state_q, state_d;
	idx_t       ri_q, ri_d;
	idx_t       wi_q, wi_d;
	idx_t       fc_q, fc_d;
	logic [7:0] br_q, br_d;
	logic       open_q, open_d;
	logic [7:0] po_q, po_d;
	cmd_t       cmd_q, cmd_d;
	logic [7:0] hd_q, hd_d;
	logic [9:0] drop_q, drop_d;
	logic [7:0] obyte_q, obyte_d;
	logic       last_q, last_d;
	status_t    status_q, status_d;

	logic       rsp_valid_q;
	logic [7:0] rsp_byte_q;
	logic       rsp_last_q;
	status_t    rsp_status_q;
	logic [9:0] rsp_drop_q;
	logic       rsp_free;

	wide_t      wi_inc_w, fc_inc_w, fit_sum, free_w, ri_sum, pop_sum, pop_sub;
	idx_t       wi_inc, fc_inc, ri_adv, pop_addr;
	logic [7:0] rec, h_sel, pay_head, pay_hd, po_inc;
	logic       wrap_need, room_short, too_large;

	assign rsp_free = !rsp_valid_q || rsp.ready;

	assign wi_inc_w = {1'b0, wi_q} + wide_t'(1);
	assign wi_inc   = (wi_inc_w == SIZE_W) ? '0 : wi_inc_w[AW-1:0];
	assign fc_inc_w = {1'b0, fc_q} + wide_t'(1);
	assign fc_inc   = (fc_inc_w == SIZE_W) ? '0 : fc_inc_w[AW-1:0];

	assign rec       = cmd_q.msg_length + 8'd1;
	assign fit_sum   = {1'b0, wi_q} + wide_t'(rec);
	assign wrap_need = (fit_sum >= SIZE_W);
	assign free_w    = (wi_q >= ri_q) ? (LAST_W - {1'b0, idx_t'(wi_q - ri_q)})
	                                  : ({1'b0, idx_t'(ri_q - wi_q)} - wide_t'(1));
	assign room_short = (free_w <= wide_t'(rec));

	assign h_sel  = (state_q == ENG_POP_BYTE) ? hd_q : rdata_q;
	assign ri_sum = {1'b0, ri_q} + wide_t'(h_sel);
	assign ri_adv = (ri_sum >= SIZE_W) ? '0 : ri_sum[AW-1:0];

	assign pop_sum  = {1'b0, ri_q} + wide_t'(po_q) + wide_t'(1);
	assign pop_sub  = pop_sum - SIZE_W;
	assign pop_addr = (pop_sum >= SIZE_W) ? pop_sub[AW-1:0] : pop_sum[AW-1:0];

	assign pay_head  = rdata_q - 8'd1;
	assign pay_hd    = hd_q - 8'd1;
	assign po_inc    = po_q + 8'd1;
	assign too_large = (po_q == 8'd0) && (pay_head >= max_read_length);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ENG_IDLE: begin
				if (q_valid) begin
					priority if (q_head.kind == CMD_BEGIN) begin
						state_d = ENG_FIT;
					end else if (q_head.kind == CMD_POP && ri_q != wi_q) begin
						state_d = ENG_POP_HEAD;
					end else begin
						state_d = ENG_EMIT;
					end
				end
			end
			ENG_FIT: begin
				state_d = (wrap_need && ri_q == '0) ? ENG_DROP_WAIT : ENG_DROP_CHECK;
			end
			ENG_DROP_CHECK: begin
				state_d = room_short ? ENG_DROP_WAIT : ENG_EMIT;
			end
			ENG_DROP_WAIT: begin
				state_d = ENG_DROP_CHECK;
			end
			ENG_POP_HEAD: begin
				if (rdata_q != 8'd0 && !too_large && pay_head != 8'd0 && po_q < pay_head) begin
					state_d = ENG_POP_BYTE;
				end else begin
					state_d = ENG_EMIT;
				end
			end
			ENG_POP_BYTE: begin
				state_d = ENG_EMIT;
			end
			ENG_EMIT: begin
				if (rsp_free) begin
					state_d = ENG_IDLE;
				end
			end
			default: begin
				state_d = ENG_IDLE;
			end
		endcase
	end

	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = wi_q;
		mem_wd   = 8'd0;
		mem_re   = 1'b0;
		mem_ra   = ri_q;
		q_pop    = 1'b0;
		ri_d     = ri_q;
		wi_d     = wi_q;
		fc_d     = fc_q;
		br_d     = br_q;
		open_d   = open_q;
		po_d     = po_q;
		cmd_d    = cmd_q;
		hd_d     = hd_q;
		drop_d   = drop_q;
		obyte_d  = obyte_q;
		last_d   = last_q;
		status_d = status_q;
		unique case (state_q)
			ENG_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					cmd_d   = q_head;
					obyte_d = 8'd0;
					last_d  = 1'b0;
					drop_d  = 10'd0;
					unique case (q_head.kind)
						CMD_BEGIN: begin
							status_d = ST_BEGIN_OK;
						end
						CMD_BEGIN_BAD: begin
							status_d = ST_BEGIN_REJECT;
						end
						CMD_PUSH: begin
							if (open_q && br_q != 8'd0) begin
								mem_we   = 1'b1;
								mem_wa   = fc_q;
								mem_wd   = q_head.data_byte;
								fc_d     = fc_inc;
								br_d     = br_q - 8'd1;
								if (br_q == 8'd1) begin
									wi_d   = fc_inc;
									open_d = 1'b0;
								end
								status_d = ST_PUSH_OK;
							end else begin
								status_d = ST_PUSH_REJECT;
							end
						end
						CMD_POP: begin
							if (ri_q == wi_q) begin
								status_d = ST_EMPTY;
							end else begin
								mem_re = 1'b1;
								mem_ra = ri_q;
							end
						end
						CMD_NOP: begin
							status_d = ST_PUSH_REJECT;
						end
						default: begin
							status_d = ST_PUSH_REJECT;
						end
					endcase
				end
			end
			ENG_FIT: begin
				open_d = 1'b0;
				if (wrap_need) begin
					mem_we = 1'b1;
					mem_wa = wi_q;
					mem_wd = 8'd0;
					wi_d   = '0;
					if (ri_q == '0) begin
						mem_re = 1'b1;
						mem_ra = '0;
					end
				end
			end
			ENG_DROP_CHECK: begin
				if (room_short) begin
					mem_re = 1'b1;
					mem_ra = ri_q;
				end else begin
					mem_we   = 1'b1;
					mem_wa   = wi_q;
					mem_wd   = rec;
					fc_d     = wi_inc;
					br_d     = cmd_q.msg_length;
					if (cmd_q.msg_length == 8'd0) begin
						wi_d = wi_inc;
					end else begin
						open_d = 1'b1;
					end
					status_d = ST_BEGIN_OK;
				end
			end
			ENG_DROP_WAIT: begin
				po_d = 8'd0;
				if (rdata_q == 8'd0) begin
					ri_d = '0;
				end else begin
					ri_d = ri_adv;
					if (drop_q != DROP_SAT) begin
						drop_d = drop_q + 10'd1;
					end
				end
			end
			ENG_POP_HEAD: begin
				hd_d = rdata_q;
				priority if (rdata_q == 8'd0) begin
					ri_d     = '0;
					po_d     = 8'd0;
					status_d = ST_WRAP;
				end else if (too_large) begin
					status_d = ST_TOO_LARGE;
				end else if (pay_head != 8'd0 && po_q < pay_head) begin
					mem_re = 1'b1;
					mem_ra = pop_addr;
				end else begin
					status_d = ST_POPPED;
					last_d   = 1'b1;
					ri_d     = ri_adv;
					po_d     = 8'd0;
				end
			end
			ENG_POP_BYTE: begin
				obyte_d  = rdata_q;
				status_d = ST_POPPED;
				if (po_inc >= pay_hd) begin
					last_d = 1'b1;
					ri_d   = ri_adv;
					po_d   = 8'd0;
				end else begin
					po_d = po_inc;
				end
			end
			ENG_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		hd_q     <= hd_d;
		drop_q   <= drop_d;
		obyte_q  <= obyte_d;
		last_q   <= last_d;
		status_q <= status_d;
		if (state_q == ENG_EMIT && rsp_free) begin
			rsp_byte_q   <= obyte_q;
			rsp_last_q   <= last_q;
			rsp_status_q <= status_q;
			rsp_drop_q   <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ENG_IDLE;
			ri_q        <= '0;
			wi_q        <= '0;
			fc_q        <= '0;
			br_q        <= 8'd0;
			open_q      <= 1'b0;
			po_q        <= 8'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ri_q    <= ri_d;
			wi_q    <= wi_d;
			fc_q    <= fc_d;
			br_q    <= br_d;
			open_q  <= open_d;
			po_q    <= po_d;
			if (state_q == ENG_EMIT && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.out_byte      = rsp_byte_q;
	assign rsp.last          = rsp_last_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.dropped_count = rsp_drop_q;

endmodule

FILE: src/length_prefixed_message_ring.sv
// ----------------------------------------------------------------------------
// length_prefixed_message_ring
// Byte ring of length-prefixed records that drops the oldest records to make
// room, with a request queue, a command engine and an APB register port.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. Requests enter a two-entry queue and
// are carried out one at a time by an engine that owns the record store, which
// has one write port and one read port with registered read data. A push, a
// rejected begin, an unknown operation and a pop on an empty ring go straight
// to emit; a pop that returns a byte visits pop-head and pop-byte, one that
// stops at a wrap marker or a too-large head, or consumes an empty record,
// pop-head alone. A begin visits fit and drop-check, with a drop-wait when it
// wraps while the head sits at index 0, and a drop-wait and drop-check
// for each further length byte or wrap marker that it reads to make room. A
// result that is not taken holds the engine until it is. The store needs no
// clearing after reset. max_read_length is written at byte address 0.
module length_prefixed_message_ring #(
	parameter int unsigned STORE_BYTES = lpmr_pkg::STORE_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lpmr_cmd_if.sink                      cmd,
	lpmr_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lpmr_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import lpmr_pkg::*;

	logic [7:0] mrl_q;
	logic       cfg_wr;
	cmd_t       q_head;
	logic       q_valid;
	logic       q_pop;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_READ_LENGTH);
	assign prdata = (paddr[2] == REG_MAX_READ_LENGTH) ? {24'd0, mrl_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mrl_q <= MRL_RESET;
		end else if (cfg_wr) begin
			mrl_q <= pwdata[7:0];
		end
	end

	lpmr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_head  (q_head),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	lpmr_back #(
		.STORE_BYTES (STORE_BYTES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.max_read_length (mrl_q),
		.q_head          (q_head),
		.q_valid         (q_valid),
		.q_pop           (q_pop),
		.rsp             (rsp)
	);

`ifndef SYNTHESIS
	// Only a begin reports dropped records.
	a_drop_only_begin: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_BEGIN_OK |-> rsp.dropped_count == 10'd0)
		else $error("dropped count on a result that is not a begin");

	// Only a popped byte carries data or the last flag.
	a_byte_only_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_POPPED |-> rsp.out_byte == 8'd0 && !rsp.last)
		else $error("byte or last flag on a result that is not a pop");
`endif

endmodule

FILE: bench/lpmr_ring_checker.sv
// ----------------------------------------------------------------------------
// lpmr_ring_checker
// Watches the request, result and register ports of the message ring, keeps
// its own copy of the ring, and compares every result with its prediction.
// ----------------------------------------------------------------------------
module lpmr_ring_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	lpmr_cmd_if                           cmd,
	lpmr_rsp_if                           rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lpmr_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	input  logic                          pready,
	output int unsigned                   mismatches,
	output int unsigned                   owed
);

	timeunit 1ns;
	timeprecision 1ps;

	import lpmr_pkg::*;

	localparam int unsigned RING_BYTES = STORE_BYTES_DEF;
	localparam logic [PADDR_W-1:0] READ_LIMIT_ADDR = PADDR_W'(4 * REG_MAX_READ_LENGTH);

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		status_t    status;
		logic [9:0] dropped_count;
	} ring_result_t;

	logic [7:0]   ring_bytes [RING_BYTES];
	int unsigned  wr_ptr;
	int unsigned  rd_ptr;
	int unsigned  fill_ptr;
	int unsigned  fill_left;
	int unsigned  pop_pos;
	bit           msg_open;
	logic [7:0]   read_limit;
	ring_result_t owed_results [$];
	ring_result_t want;

	function automatic int unsigned ring_space();
		if (wr_ptr >= rd_ptr)
			return RING_BYTES - 1 - (wr_ptr - rd_ptr);
		return rd_ptr - wr_ptr - 1;
	endfunction

	// Moves the read pointer past the head record or follows a wrap marker.
	function automatic bit discard_head();
		int unsigned hdr;
		hdr = 32'(ring_bytes[rd_ptr]);
		pop_pos = 0;
		if (hdr == 0) begin
			rd_ptr = 0;
			return 1'b0;
		end
		rd_ptr += hdr;
		if (rd_ptr >= RING_BYTES)
			rd_ptr = 0;
		return 1'b1;
	endfunction

	function automatic ring_result_t ring_outcome(input op_t op, input logic [7:0] data,
			input logic [7:0] len);
		ring_result_t r;
		int unsigned  rec_len;
		int unsigned  hdr;
		int unsigned  payload;
		int unsigned  drops;
		int unsigned  guard;
		r = '{out_byte: 8'd0, last: 1'b0, status: ST_PUSH_REJECT, dropped_count: 10'd0};
		drops = 0;
		case (op)
			OP_BEGIN: begin
				if (len == LEN_LIMIT) begin
					r.status = ST_BEGIN_REJECT;
				end else begin
					rec_len = int'(len) + 1;
					msg_open = 1'b0;
					if (rec_len > RING_BYTES - wr_ptr - 1) begin
						ring_bytes[wr_ptr] = 8'd0;
						wr_ptr = 0;
						if (rd_ptr == 0 && discard_head())
							drops++;
					end
					guard = 0;
					while (ring_space() <= rec_len && guard <= RING_BYTES) begin
						if (discard_head() && drops < DROP_SAT)
							drops++;
						guard++;
					end
					ring_bytes[wr_ptr] = rec_len[7:0];
					fill_ptr = (wr_ptr + 1) % RING_BYTES;
					fill_left = 32'(len);
					if (len == 8'd0)
						wr_ptr = fill_ptr;
					else
						msg_open = 1'b1;
					r.status = ST_BEGIN_OK;
					r.dropped_count = drops[9:0];
				end
			end
			OP_PUSH: begin
				if (msg_open && fill_left != 0) begin
					ring_bytes[fill_ptr] = data;
					fill_ptr = (fill_ptr + 1) % RING_BYTES;
					fill_left--;
					if (fill_left == 0) begin
						wr_ptr = fill_ptr;
						msg_open = 1'b0;
					end
					r.status = ST_PUSH_OK;
				end
			end
			OP_POP: begin
				if (rd_ptr == wr_ptr) begin
					r.status = ST_EMPTY;
				end else begin
					hdr = 32'(ring_bytes[rd_ptr]);
					if (hdr == 0) begin
						rd_ptr = 0;
						pop_pos = 0;
						r.status = ST_WRAP;
					end else if (pop_pos == 0 && hdr - 1 >= 32'(read_limit)) begin
						r.status = ST_TOO_LARGE;
					end else begin
						payload = hdr - 1;
						r.status = ST_POPPED;
						if (payload != 0 && pop_pos < payload) begin
							r.out_byte = ring_bytes[(rd_ptr + 1 + pop_pos) % RING_BYTES];
							pop_pos++;
						end
						if (pop_pos >= payload) begin
							r.last = 1'b1;
							rd_ptr += hdr;
							if (rd_ptr >= RING_BYTES)
								rd_ptr = 0;
							pop_pos = 0;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic void flag_field(input string field, input logic [9:0] want_v,
			input logic [9:0] got_v);
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
		mismatches++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_BYTES; i++)
				ring_bytes[i] = 8'd0;
			wr_ptr = 0;
			rd_ptr = 0;
			fill_ptr = 0;
			fill_left = 0;
			pop_pos = 0;
			msg_open = 1'b0;
			read_limit = MRL_RESET;
			owed_results.delete();
			mismatches = 0;
			owed = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == READ_LIMIT_ADDR)
				read_limit = pwdata[7:0];
			if (cmd.valid && cmd.ready)
				owed_results.push_back(ring_outcome(op_t'(cmd.operation), cmd.data_byte,
					cmd.msg_length));
			if (rsp.valid && rsp.ready) begin
				if (owed_results.size() == 0) begin
					$display("%0t: result with no request outstanding, status %0d byte %0d",
						$time, rsp.status, rsp.out_byte);
					mismatches++;
				end else begin
					want = owed_results.pop_front();
					if (rsp.out_byte !== want.out_byte)
						flag_field("out_byte", 10'(want.out_byte), 10'(rsp.out_byte));
					if (rsp.last !== want.last)
						flag_field("last", 10'(want.last), 10'(rsp.last));
					if (rsp.status !== want.status)
						flag_field("status", 10'(want.status), 10'(rsp.status));
					if (rsp.dropped_count !== want.dropped_count)
						flag_field("dropped_count", want.dropped_count, rsp.dropped_count);
				end
			end
			owed = owed_results.size();
		end
	end

endmodule

FILE: bench/tb_length_prefixed_message_ring.sv
// ----------------------------------------------------------------------------
// tb_length_prefixed_message_ring
// Drives requests and register writes into the message ring and reports the
// verdict of the checker beside it. A directed opening covers the corner
// cases; random phases under several read limits then fill, wrap and drain
// the ring with bursty requests and a stalling result receiver.
// ----------------------------------------------------------------------------
module tb_length_prefixed_message_ring;

	timeunit 1ns;
	timeprecision 1ps;

	import lpmr_pkg::*;

	localparam logic [PADDR_W-1:0] READ_LIMIT_ADDR = PADDR_W'(4 * REG_MAX_READ_LENGTH);

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	int unsigned        mismatches;
	int unsigned        owed;
	int unsigned        burst_left;
	bit                 hold_results;

	lpmr_cmd_if cmd_ch ();
	lpmr_rsp_if rsp_ch ();

	length_prefixed_message_ring uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	lpmr_ring_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.rsp        (rsp_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.mismatches (mismatches),
		.owed       (owed)
	);

	always #6 clk = ~clk;

	task automatic send_request(input op_t op, input logic [7:0] data, input logic [7:0] len);
		int unsigned idle_cycles;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			idle_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (idle_cycles != 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (idle_cycles) @(posedge clk);
			end
		end
		burst_left--;
		cmd_ch.valid <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.data_byte <= data;
		cmd_ch.msg_length <= len;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	task automatic settle_ring();
		cmd_ch.valid <= 1'b0;
		do @(negedge clk); while (owed != 0);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_read_limit(input logic [7:0] limit);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= READ_LIMIT_ADDR;
		pwdata <= {24'd0, limit};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [7:0] pick_length();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 25)
			return 8'd0;
		if (k < 75)
			return 8'($urandom_range(1, 12));
		if (k < 93)
			return 8'($urandom_range(13, 80));
		return 8'($urandom_range(81, 254));
	endfunction

	// Mostly whole messages with random content, some cut short, with pops
	// mixed in and a little stray traffic.
	task automatic run_phase(input int unsigned budget, input int unsigned pop_pct);
		int unsigned sent;
		int unsigned pick;
		int unsigned cut;
		logic [7:0]  len;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < pop_pct) begin
				send_request(OP_POP, 8'($urandom), 8'($urandom));
				sent++;
			end else if (pick < pop_pct + 8) begin
				case ($urandom_range(0, 2))
					0: send_request(OP_PUSH, 8'($urandom), 8'($urandom));
					1: send_request(OP_NONE, 8'($urandom), 8'($urandom));
					default: send_request(OP_BEGIN, 8'($urandom), LEN_LIMIT);
				endcase
				sent++;
			end else begin
				len = pick_length();
				cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
				send_request(OP_BEGIN, 8'($urandom), len);
				sent++;
				for (int i = 0; i < cut; i++) begin
					if ($urandom_range(0, 99) < pop_pct / 3) begin
						send_request(OP_POP, 8'($urandom), 8'($urandom));
						sent++;
					end
					send_request(OP_PUSH, 8'($urandom), 8'($urandom));
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.operation <= OP_NONE;
		cmd_ch.data_byte <= 8'd0;
		cmd_ch.msg_length <= 8'd0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= 32'd0;
		burst_left = 0;
		hold_results = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_POP, 8'h00, 8'h00);
		send_request(OP_PUSH, 8'hFF, 8'h00);
		send_request(OP_NONE, 8'hFF, 8'hFF);
		send_request(OP_BEGIN, 8'h00, LEN_LIMIT);
		send_request(OP_BEGIN, 8'hFF, 8'h00);
		send_request(OP_POP, 8'h00, 8'hFF);
		send_request(OP_POP, 8'hFF, 8'h00);
		send_request(OP_BEGIN, 8'h00, 8'h03);
		send_request(OP_PUSH, 8'h00, 8'hFF);
		send_request(OP_BEGIN, 8'h00, LEN_LIMIT);
		send_request(OP_PUSH, 8'hFF, 8'h00);
		send_request(OP_PUSH, 8'hA5, 8'h80);
		send_request(OP_PUSH, 8'h5A, 8'h7F);
		send_request(OP_POP, 8'h00, 8'h00);
		send_request(OP_POP, 8'h00, 8'h00);
		send_request(OP_POP, 8'h00, 8'h00);
		send_request(OP_BEGIN, 8'h00, 8'h04);
		send_request(OP_PUSH, 8'h11, 8'h00);
		send_request(OP_BEGIN, 8'h00, 8'h02);
		send_request(OP_PUSH, 8'h22, 8'h00);
		send_request(OP_PUSH, 8'h33, 8'h00);
		send_request(OP_POP, 8'h00, 8'h00);
		send_request(OP_POP, 8'h00, 8'h00);
		send_request(OP_POP, 8'h00, 8'h00);
		send_request(OP_BEGIN, 8'h00, 8'd254);

		settle_ring();
		write_read_limit(8'd255);
		run_phase(380, 30);

		settle_ring();
		write_read_limit(8'd1);
		hold_results = 1'b1;
		run_phase(380, 25);

		settle_ring();
		write_read_limit(8'd128);
		run_phase(380, 55);

		settle_ring();
		write_read_limit(8'd9);
		run_phase(380, 15);

		settle_ring();
		write_read_limit(8'($urandom_range(1, 255)));
		run_phase(380, 40);

		settle_ring();
		if (mismatches == 0)
			$display("length_prefixed_message_ring verification clean");
		else
			$display("length_prefixed_message_ring verification failed");
		$finish;
	end

	initial begin
		int unsigned style;
		int unsigned span;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_results) begin
				rsp_ch.ready <= 1'b0;
				repeat (500) @(posedge clk);
				hold_results = 1'b0;
			end
			style = $urandom_range(0, 2);
			span = $urandom_range(16, 96);
			for (int i = 0; i < span; i++) begin
				case (style)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					default: rsp_ch.ready <= (i % 3 == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		#10ms;
		$display("length_prefixed_message_ring verification failed");
		$finish;
	end

endmodule
